### rtl/lzwe_pkg.sv
// Shared types and constants for the message-alphabet LZW encoder.
package lzwe_pkg;

    localparam int DICT_DEPTH_DEF = 4096;
    localparam int CODE_W         = 12;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int KEY_W          = CODE_W + BYTE_W;
    localparam int RANK_W         = 9;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT_BYTE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALPHA_LATE   = 2'd2;

    localparam logic REQ_ALPHABET = 1'b0;
    localparam logic REQ_ENCODE   = 1'b1;

    typedef enum logic [1:0] {
        OSEL_ALPHA_LATE,
        OSEL_ABSENT,
        OSEL_PHRASE_MID,
        OSEL_PHRASE_LAST
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     alpha_mark;
        logic     out_load;
        out_sel_t out_sel;
        logic     rank_start;
        logic     rank_step;
        logic     scan_start;
        logic     scan_run;
        logic     set_phrase_bc;
        logic     set_phrase_found;
        logic     miss_commit;
        logic     clear_all;
    } cmd_t;

    typedef struct packed {
        logic req;
        logic last;
        logic present;
        logic have;
        logic rank_last;
        logic scan_found;
        logic scan_miss;
        logic out_free;
    } stat_t;

endpackage

### rtl/lzwe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwe_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/lzwe_ctrl.sv
// Control state machine sequencing one input word at a time.
module lzwe_ctrl import lzwe_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_EVAL      = 9'b000000010,
        S_RANK      = 9'b000000100,
        S_DECIDE    = 9'b000001000,
        S_SCAN      = 9'b000010000,
        S_EMIT_MISS = 9'b000100000,
        S_EMIT_ERR  = 9'b001000000,
        S_FIN       = 9'b010000000,
        S_EMIT_LAST = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OSEL_PHRASE_MID;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.req == REQ_ALPHABET) begin
                    if (stat.have) begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OSEL_ALPHA_LATE;
                            state_next   = S_IDLE;
                        end
                    end else begin
                        cmd.alpha_mark = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (!stat.present) begin
                    state_next = S_EMIT_ERR;
                end else begin
                    cmd.rank_start = 1'b1;
                    state_next     = S_RANK;
                end
            end
            S_RANK: begin
                cmd.rank_step = 1'b1;
                if (stat.rank_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!stat.have) begin
                    cmd.set_phrase_bc = 1'b1;
                    state_next        = S_FIN;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_found) begin
                    cmd.set_phrase_found = 1'b1;
                    state_next           = S_FIN;
                end else if (stat.scan_miss) begin
                    state_next = S_EMIT_MISS;
                end
            end
            S_EMIT_MISS: begin
                if (stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = OSEL_PHRASE_MID;
                    cmd.miss_commit = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_EMIT_ERR: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_ABSENT;
                    state_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (!stat.last) begin
                    state_next = S_IDLE;
                end else if (stat.have) begin
                    state_next = S_EMIT_LAST;
                end else begin
                    cmd.clear_all = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = OSEL_PHRASE_LAST;
                    cmd.clear_all = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/lzwe_dpath.sv
// Datapath: alphabet mask, rank counter, dictionary scan and output register.
module lzwe_dpath import lzwe_pkg::*; #(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_req_type,
    input  logic [BYTE_W-1:0]   s_byte_value,
    input  logic                s_is_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CODE_W-1:0]   m_code,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last_of_run,
    input  cmd_t                cmd,
    output stat_t               stat
);

    localparam int AW = $clog2(DICT_DEPTH);
    localparam int NW = AW + 1;
    localparam int SW = NW + 1;
    localparam int FW = (SW > CODE_W) ? SW : CODE_W;

    logic              req_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic [255:0]       mask_reg;
    logic [RANK_W-1:0]  k_reg;
    logic [NW-1:0]      next_reg;
    logic [CODE_W-1:0]  phrase_reg;
    logic               have_reg;

    logic [4:0]         rank_idx_reg;
    logic [RANK_W-1:0]  acc_reg;
    logic [NW-1:0]      scan_idx_reg;
    logic [NW-1:0]      cmp_idx_reg;
    logic               rv_reg;

    logic                m_valid_reg;
    logic [CODE_W-1:0]   m_code_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_last_reg;

    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  rdata;
    logic              issue;
    logic              room;
    logic              we;
    logic [3:0]        chunk_cnt;
    logic [CODE_W-1:0] bc_code;
    logic [CODE_W-1:0] found_code;

    assign key     = {phrase_reg, byte_reg};
    assign issue   = cmd.scan_run && (scan_idx_reg < next_reg);
    assign room    = ((SW'(k_reg) + SW'(next_reg)) < SW'(DICT_DEPTH - 1))
                     && (next_reg < NW'(DICT_DEPTH));
    assign we      = cmd.miss_commit && room;
    assign bc_code = CODE_W'(acc_reg) + CODE_W'(1);
    assign found_code = CODE_W'(FW'(k_reg) + FW'(1) + FW'(cmp_idx_reg));

    // Count present bytes below the current byte, eight mask bits per step.
    always_comb begin
        logic [BYTE_W-1:0] pos;
        chunk_cnt = '0;
        for (int j = 0; j < 8; j++) begin
            pos = {rank_idx_reg, 3'(j)};
            if (mask_reg[pos] && (pos < byte_reg)) begin
                chunk_cnt = chunk_cnt + 4'd1;
            end
        end
    end

    lzwe_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .aclk  (aclk),
        .we    (we),
        .waddr (next_reg[AW-1:0]),
        .wdata (key),
        .re    (issue),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_req_type;
            byte_reg <= s_byte_value;
            last_reg <= s_is_last;
        end
        if (cmd.rank_start) begin
            rank_idx_reg <= '0;
            acc_reg      <= '0;
        end else if (cmd.rank_step) begin
            rank_idx_reg <= rank_idx_reg + 5'd1;
            acc_reg      <= acc_reg + RANK_W'(chunk_cnt);
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (issue) begin
            scan_idx_reg <= scan_idx_reg + NW'(1);
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                OSEL_ALPHA_LATE: begin
                    m_code_reg   <= '0;
                    m_status_reg <= ST_ALPHA_LATE;
                    m_last_reg   <= 1'b0;
                end
                OSEL_ABSENT: begin
                    m_code_reg   <= '0;
                    m_status_reg <= ST_ABSENT_BYTE;
                    m_last_reg   <= last_reg && !have_reg;
                end
                OSEL_PHRASE_MID: begin
                    m_code_reg   <= phrase_reg;
                    m_status_reg <= ST_OK;
                    m_last_reg   <= 1'b0;
                end
                OSEL_PHRASE_LAST: begin
                    m_code_reg   <= phrase_reg;
                    m_status_reg <= ST_OK;
                    m_last_reg   <= 1'b1;
                end
                default: begin
                    m_code_reg   <= '0;
                    m_status_reg <= ST_OK;
                    m_last_reg   <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            k_reg       <= '0;
            next_reg    <= '0;
            phrase_reg  <= '0;
            have_reg    <= 1'b0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rv_reg <= issue;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clear_all) begin
                mask_reg   <= '0;
                k_reg      <= '0;
                next_reg   <= '0;
                phrase_reg <= '0;
                have_reg   <= 1'b0;
            end else begin
                if (cmd.alpha_mark && !mask_reg[byte_reg]) begin
                    mask_reg[byte_reg] <= 1'b1;
                    k_reg              <= k_reg + RANK_W'(1);
                end
                if (cmd.set_phrase_bc) begin
                    phrase_reg <= bc_code;
                    have_reg   <= 1'b1;
                end
                if (cmd.set_phrase_found) begin
                    phrase_reg <= found_code;
                end
                if (cmd.miss_commit) begin
                    phrase_reg <= bc_code;
                    if (room) begin
                        next_reg <= next_reg + NW'(1);
                    end
                end
            end
        end
    end

    assign stat.req        = req_reg;
    assign stat.last       = last_reg;
    assign stat.present    = mask_reg[byte_reg];
    assign stat.have       = have_reg;
    assign stat.rank_last  = (rank_idx_reg == 5'd31);
    assign stat.scan_found = rv_reg && (rdata == key);
    assign stat.scan_miss  = !rv_reg && !(scan_idx_reg < next_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_code        = m_code_reg;
    assign m_status      = m_status_reg;
    assign m_last_of_run = m_last_reg;

endmodule

### rtl/lzw_encoder_message_alphabet.sv
// LZW encoder with a base dictionary built from the bytes present in the message.
//
// Usage: send the message twice on the s_ channel. Words with req_type 0 mark
// their byte as present and give no result (an alpha-late error if a phrase is
// open). Words with req_type 1 encode; the word with is_last set closes the
// message, flushes the open phrase with last_of_run set and clears the alphabet
// and dictionary. Each word gives zero, one or two result words on the m_ channel
// (code, status, last_of_run). Errors carry code 0 with a nonzero status.
// Throughput: one word at a time. An alphabet word is accepted, then evaluated.
// An encode word with a present byte goes through accept, evaluate, a 32-step
// rank count over the 256-bit alphabet mask, decide and finish. With a phrase
// open a linear scan of the dictionary RAM, one read a cycle, comes between
// decide and finish. Each result word is loaded into the output register once
// it is free; it shows on m_ the cycle after it is loaded.
// Reset (aresetn low, synchronous) empties the alphabet and dictionary.
// A stalled receiver holds the one-deep output register; the block still
// takes the next input word and only waits once it has another result ready.
module lzw_encoder_message_alphabet import lzwe_pkg::*; #(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [BYTE_W-1:0]   s_byte_value,
    input  logic                s_is_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CODE_W-1:0]   m_code,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last_of_run
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: accept a word, rank, scan, emit, finish.
    lzwe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and arithmetic, plus the output register.
    lzwe_dpath #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_byte_value  (s_byte_value),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code        (m_code),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .stat          (stat)
    );

`ifndef SYNTH
    // An ok result always carries a real code.
    a_ok_code : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (m_code != '0))
        else $error("ok result with zero code");

    // An error result carries code zero.
    a_err_code : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_code == '0))
        else $error("error result with nonzero code");

    // One word in flight: the input closes right after an accept.
    a_one_word : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened while a word is in work");
`endif

endmodule

### sim/lzw_encoder_message_alphabet_tb.sv
// Self-checking testbench for the message-alphabet LZW encoder.
module lzw_encoder_message_alphabet_tb;
    import lzwe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = DICT_DEPTH_DEF;
    localparam int WDOG_MAX  = 200000;
    localparam int HOLD_LONG = 3000;

    typedef struct packed {
        logic              req;
        logic [BYTE_W-1:0] bval;
        logic              last;
    } in_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic                last;
    } code_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_req_type = 1'b0;
    logic [BYTE_W-1:0]   s_byte_value = '0;
    logic                s_is_last = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CODE_W-1:0]   m_code;
    logic [STATUS_W-1:0] m_status;
    logic                m_last_of_run;

    lzw_encoder_message_alphabet #(.DICT_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_byte_value(s_byte_value), .s_is_last(s_is_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_code(m_code),
        .m_status(m_status), .m_last_of_run(m_last_of_run)
    );

    // Encoder mirror state.
    logic              present_mask [256];
    logic [KEY_W-1:0]  added_keys [DEPTH];
    int unsigned       n_added;
    logic [CODE_W-1:0] cur_phrase;
    logic              phrase_open;

    in_word_t   pending_words[$];
    code_word_t expected_codes[$];
    int         n_errors = 0;
    bit         stim_done = 1'b0;
    // Long receiver hold right after reset while the sender keeps offering.
    int         hold_count = HOLD_LONG;
    int         idle_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned rank_below(int unsigned b);
        int unsigned n;
        n = 0;
        for (int i = 0; i < b; i++) n += present_mask[i];
        return n;
    endfunction

    function automatic void clear_encoder();
        for (int i = 0; i < 256; i++) present_mask[i] = 1'b0;
        n_added     = 0;
        cur_phrase  = '0;
        phrase_open = 1'b0;
    endfunction

    // Append one expected result word.
    function automatic void expect_word(logic [CODE_W-1:0] code,
                                        logic [STATUS_W-1:0] status, logic last);
        code_word_t c;
        c = '{code, status, last};
        expected_codes.insert(expected_codes.size(), c);
    endfunction

    // Append one input word to the driver's queue.
    function automatic void queue_word(logic req, logic [BYTE_W-1:0] bval, logic last);
        in_word_t w;
        w = '{req, bval, last};
        pending_words.insert(pending_words.size(), w);
    endfunction

    // Work out the codes that one accepted word produces.
    function automatic void encode_word(in_word_t w);
        int unsigned      k;
        int unsigned      bc;
        int               hit;
        logic [KEY_W-1:0] key;
        if (w.req == REQ_ALPHABET) begin
            if (phrase_open) expect_word('0, ST_ALPHA_LATE, 1'b0);
            else present_mask[w.bval] = 1'b1;
            return;
        end
        k = rank_below(256);
        if (!present_mask[w.bval]) begin
            expect_word('0, ST_ABSENT_BYTE, w.last && !phrase_open);
        end else begin
            bc = rank_below(w.bval) + 1;
            if (!phrase_open) begin
                cur_phrase  = bc[CODE_W-1:0];
                phrase_open = 1'b1;
            end else begin
                key = {cur_phrase, w.bval};
                hit = -1;
                for (int i = 0; i < n_added; i++) begin
                    if (added_keys[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    cur_phrase = CODE_W'(k + 1 + hit);
                end else begin
                    expect_word(cur_phrase, ST_OK, 1'b0);
                    // Freeze the table once the code space is used up.
                    if (k + n_added < DEPTH - 1) begin
                        added_keys[n_added] = key;
                        n_added++;
                    end
                    cur_phrase = bc[CODE_W-1:0];
                end
            end
        end
        if (w.last) begin
            if (phrase_open) expect_word(cur_phrase, ST_OK, 1'b1);
            clear_encoder();
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Queue one message: alphabet pass, then encode pass over the same bytes.
    task automatic add_message(logic [BYTE_W-1:0] msg[$], bit corrupt);
        foreach (msg[i]) queue_word(REQ_ALPHABET, msg[i], 1'($urandom_range(0, 1)));
        foreach (msg[i]) begin
            in_word_t w;
            w = '{REQ_ENCODE, msg[i], i == msg.size() - 1};
            // Inject a late alphabet word or a random, possibly absent byte now and then.
            if (corrupt && i > 0 && $urandom_range(0, 9) == 0)
                queue_word(REQ_ALPHABET, BYTE_W'($urandom), 1'b0);
            if (corrupt && $urandom_range(0, 9) == 0) w.bval = BYTE_W'($urandom);
            pending_words.insert(pending_words.size(), w);
        end
    endtask

    // Driver: hold valid until accepted, then wait a random gap.
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_words.pop_front();
                gap_left <= $urandom_range(0, 9);
                s_valid  <= 1'b0;
            end else if (!s_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() > 0) begin
                    s_valid      <= 1'b1;
                    s_req_type   <= pending_words[0].req;
                    s_byte_value <= pending_words[0].bval;
                    s_is_last    <= pending_words[0].last;
                end
            end
        end
    end

    // Predict at acceptance so order matches the block.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            encode_word('{s_req_type, s_byte_value, s_is_last});
    end

    // Monitor: compare each accepted code word with the oldest expectation.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected word", m_code, -1);
                end else begin
                    code_word_t e;
                    e = expected_codes.pop_front();
                    if (m_code != e.code) report_mismatch("code", m_code, e.code);
                    if (m_status != e.status) report_mismatch("status", m_status, e.status);
                    if (m_last_of_run != e.last)
                        report_mismatch("last_of_run", m_last_of_run, e.last);
                end
            end
            // Hold off the receiver once for a long stretch, then random stalls.
            if (hold_count > 0) begin
                hold_count <= hold_count - 1;
                m_ready    <= 1'b0;
            end else if (m_valid && m_ready) begin
                stall_left <= $urandom_range(0, 9);
                m_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_count > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] msg[$];
        int total;
        int len;
        clear_encoder();
        // Directed: extreme bytes, repeats that grow phrases, an absent byte,
        // a late alphabet word and a lone absent last byte.
        msg = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00};
        add_message(msg, 1'b0);
        queue_word(REQ_ALPHABET, 8'h41, 1'b0);
        queue_word(REQ_ENCODE, 8'h41, 1'b0);
        queue_word(REQ_ALPHABET, 8'h42, 1'b1);
        queue_word(REQ_ENCODE, 8'h7f, 1'b0);
        queue_word(REQ_ENCODE, 8'h41, 1'b0);
        queue_word(REQ_ENCODE, 8'h80, 1'b1);
        queue_word(REQ_ENCODE, 8'h55, 1'b1);
        queue_word(REQ_ALPHABET, 8'h10, 1'b0);
        queue_word(REQ_ENCODE, 8'h10, 1'b1);
        total = pending_words.size();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (total < 1100) begin
            msg = {};
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                msg.insert(msg.size(), BYTE_W'($urandom_range(0, 3) == 0 ?
                                                $urandom : $urandom_range(60, 63)));
            add_message(msg, $urandom_range(0, 2) == 0);
            total += 2 * len;
        end
        while (pending_words.size() > 0 || s_valid) @(posedge aclk);
        while (expected_codes.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (n_errors == 0 && expected_codes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
